### design/ptmw_pkg.sv
// Package for the page table map and walk block.
// Holds sizes, status codes and the controller/datapath command and status types.
// No dependencies.
`timescale 1ns / 1ps

package ptmw_pkg;

    localparam int TABLE_SLOTS = 64;
    localparam int LEVELS      = 4;
    localparam int INDEX_BITS  = 9;
    localparam int PAGE_SHIFT  = 12;

    localparam int ENTRIES  = 1 << INDEX_BITS;
    localparam int SLOT_W   = $clog2(TABLE_SLOTS);
    localparam int CNT_W    = $clog2(TABLE_SLOTS + 1);
    localparam int LVL_W    = $clog2(LEVELS + 1);
    localparam int ADDR_W   = SLOT_W + INDEX_BITS;
    localparam int FRAME_W  = 40;
    localparam int VA_W     = 48;
    localparam int PA_W     = 52;
    localparam int VA_EXT_W = 64;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_MAPPED     = 2'd1;
    localparam logic [1:0] ST_NO_SLOTS   = 2'd2;
    localparam logic [1:0] ST_NOT_MAPPED = 2'd3;

    localparam logic CMD_MAP     = 1'b0;
    localparam logic CMD_RESOLVE = 1'b1;

    typedef struct packed {
        logic       load;
        logic       rd;
        logic       clr_root;
        logic       descend;
        logic       alloc;
        logic       clr_new;
        logic       leaf_wr;
        logic       done;
        logic [1:0] status;
    } t_dp_cmd;

    typedef struct packed {
        logic present;
        logic bad_slot;
        logic full;
        logic leaf;
        logic resolve;
    } t_dp_stat;

endpackage

### design/page_table_map_and_walk_top.sv
// Top level of the page table map and walk block.
// Instantiates ptmw_ctrl and ptmw_dp; depends on ptmw_pkg.
//
// Usage:
//   Request channel: drive i_cmd, i_virt_addr, i_phys_addr_in and raise start;
//   the beat is taken at a clock edge where start is high and busy is low.
//   i_cmd low maps the page of i_virt_addr to the frame of i_phys_addr_in;
//   i_cmd high resolves i_virt_addr to a physical address.
//   Result channel: o_done is high for exactly one cycle per request, with
//   o_status (ok, already mapped, out of table slots, not mapped) and
//   o_phys_addr_out (nonzero only for a successful resolve).
//   Sequencing: each level passes through a table read state and a decision
//   state, and each table created during a map adds a state for clearing its
//   present row; a walk that stops early returns sooner. One request is in
//   flight at a time; busy falls as o_done rises, so no new request is taken
//   before o_done rises.
//   Reset: busy is high for one cycle after reset while the root table's
//   present row is cleared; the slot counter restarts at one.
//   The receiver cannot stall: every o_done beat is taken as it appears.
`timescale 1ns / 1ps

module page_table_map_and_walk_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cmd,
    input  logic [ptmw_pkg::VA_W-1:0]  i_virt_addr,
    input  logic [ptmw_pkg::PA_W-1:0]  i_phys_addr_in,
    output logic                       o_done,
    output logic [1:0]                 o_status,
    output logic [ptmw_pkg::PA_W-1:0]  o_phys_addr_out
);

    ptmw_pkg::t_dp_cmd  dp_cmd;
    ptmw_pkg::t_dp_stat dp_stat;

    ptmw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_dp_stat (dp_stat),
        .o_dp_cmd  (dp_cmd)
    );

    ptmw_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (i_cmd),
        .i_virt_addr     (i_virt_addr),
        .i_phys_addr_in  (i_phys_addr_in),
        .i_dp_cmd        (dp_cmd),
        .o_dp_stat       (dp_stat),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_phys_addr_out (o_phys_addr_out)
    );

endmodule

### design/ptmw_dp.sv
// Datapath of the page table map and walk block: table stores, walk registers,
// slot counter and result registers. Depends on ptmw_pkg.
`timescale 1ns / 1ps

module ptmw_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd,
    input  logic [ptmw_pkg::VA_W-1:0]  i_virt_addr,
    input  logic [ptmw_pkg::PA_W-1:0]  i_phys_addr_in,
    input  ptmw_pkg::t_dp_cmd          i_dp_cmd,
    output ptmw_pkg::t_dp_stat         o_dp_stat,
    output logic                       o_done,
    output logic [1:0]                 o_status,
    output logic [ptmw_pkg::PA_W-1:0]  o_phys_addr_out
);

    logic [ptmw_pkg::ENTRIES-1:0]   r_pres_mem [ptmw_pkg::TABLE_SLOTS];
    logic [ptmw_pkg::FRAME_W-1:0]   r_frame_mem [ptmw_pkg::TABLE_SLOTS * ptmw_pkg::ENTRIES];

    logic                            r_cmd;
    logic [ptmw_pkg::VA_W-1:0]       r_va;
    logic [ptmw_pkg::FRAME_W-1:0]    r_pfn;
    logic [ptmw_pkg::SLOT_W-1:0]     r_slot;
    logic [ptmw_pkg::LVL_W-1:0]      r_lvl;
    logic [ptmw_pkg::CNT_W-1:0]      r_next;
    logic [ptmw_pkg::ENTRIES-1:0]    r_row;
    logic [ptmw_pkg::FRAME_W-1:0]    r_frame;
    logic                            r_done;
    logic [1:0]                      r_status;
    logic [ptmw_pkg::PA_W-1:0]       r_pa_out;

    logic [ptmw_pkg::VA_EXT_W-1:0]   va_ext;
    logic [ptmw_pkg::INDEX_BITS-1:0] idx;
    logic [ptmw_pkg::ADDR_W-1:0]     ent_addr;
    logic [ptmw_pkg::ENTRIES-1:0]    row_set;

    assign va_ext = {{(ptmw_pkg::VA_EXT_W - ptmw_pkg::VA_W){1'b0}}, r_va};

    always_comb begin
        idx = '0;
        for (int l = 1; l <= ptmw_pkg::LEVELS; l++) begin
            if (r_lvl == ptmw_pkg::LVL_W'(l)) begin
                idx = va_ext[ptmw_pkg::PAGE_SHIFT + (l - 1) * ptmw_pkg::INDEX_BITS +:
                             ptmw_pkg::INDEX_BITS];
            end
        end
    end

    assign ent_addr = {r_slot, idx};

    always_comb begin
        row_set      = r_row;
        row_set[idx] = 1'b1;
    end

    assign o_dp_stat.present  = r_row[idx];
    assign o_dp_stat.bad_slot = (r_frame >= ptmw_pkg::FRAME_W'(ptmw_pkg::TABLE_SLOTS));
    assign o_dp_stat.full     = (r_next >= ptmw_pkg::CNT_W'(ptmw_pkg::TABLE_SLOTS));
    assign o_dp_stat.leaf     = (r_lvl == ptmw_pkg::LVL_W'(1));
    assign o_dp_stat.resolve  = (r_cmd == ptmw_pkg::CMD_RESOLVE);

    // present-bit rows: read a whole table row, write back set or cleared rows
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.rd) begin
            r_row <= r_pres_mem[r_slot];
        end
        priority if (i_dp_cmd.clr_root) begin
            r_pres_mem[0] <= '0;
        end else if (i_dp_cmd.clr_new) begin
            r_pres_mem[r_slot] <= '0;
        end else if (i_dp_cmd.alloc || i_dp_cmd.leaf_wr) begin
            r_pres_mem[r_slot] <= row_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.rd) begin
            r_frame <= r_frame_mem[ent_addr];
        end
        priority if (i_dp_cmd.alloc) begin
            r_frame_mem[ent_addr] <= ptmw_pkg::FRAME_W'(r_next);
        end else if (i_dp_cmd.leaf_wr) begin
            r_frame_mem[ent_addr] <= r_pfn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_cmd <= i_cmd;
            r_va  <= i_virt_addr;
            r_pfn <= i_phys_addr_in[ptmw_pkg::PAGE_SHIFT +: ptmw_pkg::FRAME_W];
        end
        priority if (i_dp_cmd.load) begin
            r_slot <= '0;
            r_lvl  <= ptmw_pkg::LVL_W'(ptmw_pkg::LEVELS);
        end else if (i_dp_cmd.descend) begin
            r_slot <= r_frame[ptmw_pkg::SLOT_W-1:0];
            r_lvl  <= r_lvl - ptmw_pkg::LVL_W'(1);
        end else if (i_dp_cmd.alloc) begin
            r_slot <= r_next[ptmw_pkg::SLOT_W-1:0];
        end else if (i_dp_cmd.clr_new) begin
            r_lvl  <= r_lvl - ptmw_pkg::LVL_W'(1);
        end
        if (i_dp_cmd.done) begin
            r_status <= i_dp_cmd.status;
            if (i_dp_cmd.status == ptmw_pkg::ST_OK && r_cmd == ptmw_pkg::CMD_RESOLVE) begin
                r_pa_out <= {r_frame, r_va[ptmw_pkg::PAGE_SHIFT-1:0]};
            end else begin
                r_pa_out <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next <= ptmw_pkg::CNT_W'(1);
            r_done <= 1'b0;
        end else begin
            r_done <= i_dp_cmd.done;
            if (i_dp_cmd.alloc) begin
                r_next <= r_next + ptmw_pkg::CNT_W'(1);
            end
        end
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_phys_addr_out = r_pa_out;

endmodule

### design/ptmw_ctrl.sv
// Controller of the page table map and walk block: sequences reads, table
// creation, leaf writes and results. Depends on ptmw_pkg.
`timescale 1ns / 1ps

module ptmw_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ptmw_pkg::t_dp_stat  i_dp_stat,
    output ptmw_pkg::t_dp_cmd   o_dp_cmd
);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_ALLOC = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state  = r_state;
        o_dp_cmd = '0;
        unique case (r_state)
            S_CLR: begin
                o_dp_cmd.clr_root = 1'b1;
                n_state           = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_dp_cmd.load = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_RD: begin
                o_dp_cmd.rd = 1'b1;
                n_state     = S_EVAL;
            end
            S_EVAL: begin
                n_state = S_IDLE;
                priority if (i_dp_stat.leaf) begin
                    o_dp_cmd.done = 1'b1;
                    if (i_dp_stat.resolve) begin
                        o_dp_cmd.status = i_dp_stat.present ? ptmw_pkg::ST_OK
                                                            : ptmw_pkg::ST_NOT_MAPPED;
                    end else if (i_dp_stat.present) begin
                        o_dp_cmd.status = ptmw_pkg::ST_MAPPED;
                    end else begin
                        o_dp_cmd.leaf_wr = 1'b1;
                        o_dp_cmd.status  = ptmw_pkg::ST_OK;
                    end
                end else if (i_dp_stat.present && !i_dp_stat.bad_slot) begin
                    o_dp_cmd.descend = 1'b1;
                    n_state          = S_RD;
                end else if (i_dp_stat.resolve) begin
                    o_dp_cmd.done   = 1'b1;
                    o_dp_cmd.status = ptmw_pkg::ST_NOT_MAPPED;
                end else if (i_dp_stat.present || i_dp_stat.full) begin
                    o_dp_cmd.done   = 1'b1;
                    o_dp_cmd.status = ptmw_pkg::ST_NO_SLOTS;
                end else begin
                    o_dp_cmd.alloc = 1'b1;
                    n_state        = S_ALLOC;
                end
            end
            S_ALLOC: begin
                o_dp_cmd.clr_new = 1'b1;
                n_state          = S_RD;
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule
